FILE: rtl/core/wsh_pkg.sv
// Shared types and constants for the window stack with hit-to-front.
// No dependencies; imported by wsh_hit, window_stack_hit_to_front and wsh_checker.
`default_nettype none

package wsh_pkg;

   localparam int COORD_W         = 16;
   localparam int ID_W            = 16;
   localparam int POS_W           = 4;
   localparam int CNT_W           = 5;
   localparam int POS_LIMIT       = 16;
   localparam int MAX_WINDOWS_DEF = 16;
   localparam int REQ_DATA_W      = 120;
   localparam int RSP_DATA_W      = 24;

   localparam logic [1:0] OP_LOAD  = 2'd0;
   localparam logic [1:0] OP_CLICK = 2'd1;
   localparam logic [1:0] OP_DUMP  = 2'd2;

   localparam logic KIND_CLICK = 1'b0;
   localparam logic KIND_DUMP  = 1'b1;

   typedef struct packed {
      logic [ID_W-1:0]           id;
      logic signed [COORD_W-1:0] left;
      logic signed [COORD_W-1:0] top;
      logic signed [COORD_W-1:0] right;
      logic signed [COORD_W-1:0] bottom;
   } window_type;

   localparam int WINDOW_W = $bits(window_type);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_SH_RD,
      ST_SH_WR,
      ST_CLK_OUT,
      ST_DUMP_RD,
      ST_DUMP_OUT
   } state_type;

endpackage

`default_nettype wire

FILE: rtl/core/wsh_ram.sv
// Generic single-write, single-read synchronous RAM with registered read.
// Depends on nothing; read data holds while rd_en is low.
`default_nettype none

module wsh_ram #(
   parameter int  WIDTH = 8,
   parameter int  DEPTH = 16,
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [AW-1:0]    rd_addr,
   output      logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

FILE: rtl/core/wsh_hit.sv
// Inclusive rectangle containment test of one window against a point.
// Depends on wsh_pkg for the window record.
`default_nettype none

module wsh_hit
   import wsh_pkg::*;
(
   input  wire window_type                win,
   input  wire logic signed [COORD_W-1:0] point_x,
   input  wire logic signed [COORD_W-1:0] point_y,
   output      logic                      hit
);

   always_comb begin
      hit = (win.left <= point_x) && (point_x <= win.right) &&
            (win.bottom <= point_y) && (point_y <= win.top);
   end

endmodule

`default_nettype wire

FILE: rtl/core/window_stack_hit_to_front.sv
// Window stack with hit-to-front. Load writes the addressed slot. Click: scan
// reads one slot a cycle via the RAM read port, testing the slot read before;
// a hit at i shifts entries i-1..0 down, each by a read and a write state, and
// puts the hit window in slot 0. Dump reads each entry, then outputs it.
// Synchronous active-high reset clears the FSM, the window count and the
// result valid flag; the window RAM keeps no reset and is valid once loaded.
// Depends on wsh_pkg, wsh_ram and wsh_hit.
`default_nettype none

module window_stack_hit_to_front
   import wsh_pkg::*;
#(
   parameter int MAX_WINDOWS = MAX_WINDOWS_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   // request channel
   input  wire logic                  req_tvalid,
   output      logic                  req_tready,
   // tdata, low bit up: slot[4], window_id[16], left_x[16], top_y[16],
   // right_x[16], bottom_y[16], point_x[16], point_y[16], zero pad[4]
   input  wire logic [REQ_DATA_W-1:0] req_tdata,
   // tuser: opcode[2]
   input  wire logic [1:0]            req_tuser,
   // response channel
   output      logic                  rsp_tvalid,
   input  wire logic                  rsp_tready,
   // tdata, low bit up: hit[1], position[4], result_id[16], zero pad[3]
   output      logic [RSP_DATA_W-1:0] rsp_tdata,
   // tuser: kind[1]
   output      logic                  rsp_tuser,
   output      logic                  rsp_tlast,
   // window_count register
   input  wire logic                  csr_wr_en,
   input  wire logic [CNT_W-1:0]      csr_wr_data
);

   localparam int AW  = (MAX_WINDOWS > 1) ? $clog2(MAX_WINDOWS) : 1;
   // usable depth: store size, never more than the position field allows
   localparam int CAP = (MAX_WINDOWS < POS_LIMIT) ? MAX_WINDOWS : POS_LIMIT;
   localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAP);

   // request field unpack
   logic [POS_W-1:0]          req_slot;
   window_type                req_win;
   logic signed [COORD_W-1:0] req_px;
   logic signed [COORD_W-1:0] req_py;

   assign req_slot       = req_tdata[3:0];
   assign req_win.id     = req_tdata[19:4];
   assign req_win.left   = req_tdata[35:20];
   assign req_win.top    = req_tdata[51:36];
   assign req_win.right  = req_tdata[67:52];
   assign req_win.bottom = req_tdata[83:68];
   assign req_px         = req_tdata[99:84];
   assign req_py         = req_tdata[115:100];

   // config register
   logic [CNT_W-1:0] window_count_ff;
   logic [CNT_W-1:0] n_sat;

   always_ff @(posedge clock) begin
      if (reset) begin
         window_count_ff <= '0;
      end else if (csr_wr_en) begin
         window_count_ff <= csr_wr_data;
      end
   end

   assign n_sat = (window_count_ff > CAP_CNT) ? CAP_CNT : window_count_ff;

   // control and working registers
   state_type                 state_ff, state_in;
   logic [CNT_W-1:0]          n_ff, n_in;
   logic [CNT_W-1:0]          idx_ff, idx_in;   // next slot to read
   logic [CNT_W-1:0]          j_ff, j_in;       // shift destination
   logic                      chk_ff, chk_in;   // RAM data valid for idx-1
   logic                      hit_ff, hit_in;
   logic [POS_W-1:0]          pos_ff, pos_in;
   window_type                moved_ff, moved_in;
   logic signed [COORD_W-1:0] px_ff, px_in;
   logic signed [COORD_W-1:0] py_ff, py_in;

   // result register
   logic             rsp_valid_ff, rsp_valid_in;
   logic             rsp_kind_ff, rsp_kind_in;
   logic             rsp_hit_ff, rsp_hit_in;
   logic [POS_W-1:0] rsp_pos_ff, rsp_pos_in;
   logic [ID_W-1:0]  rsp_id_ff, rsp_id_in;
   logic             rsp_last_ff, rsp_last_in;
   logic             rsp_load;
   logic             out_free;

   // RAM port controls
   logic          ram_wr_en;
   logic [AW-1:0] ram_wr_addr;
   window_type    ram_wr_data;
   logic          ram_rd_en;
   logic [AW-1:0] ram_rd_addr;
   window_type    ram_rd_data;
   logic          win_hit;
   logic          req_acc;

   wsh_ram #(
      .WIDTH (WINDOW_W),
      .DEPTH (MAX_WINDOWS)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   wsh_hit u_hit (
      .win     (ram_rd_data),
      .point_x (px_ff),
      .point_y (py_ff),
      .hit     (win_hit)
   );

   assign req_tready = (state_ff == ST_IDLE);
   assign req_acc    = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      n_ff        <= n_in;
      idx_ff      <= idx_in;
      j_ff        <= j_in;
      chk_ff      <= chk_in;
      hit_ff      <= hit_in;
      pos_ff      <= pos_in;
      moved_ff    <= moved_in;
      px_ff       <= px_in;
      py_ff       <= py_in;
      rsp_kind_ff <= rsp_kind_in;
      rsp_hit_ff  <= rsp_hit_in;
      rsp_pos_ff  <= rsp_pos_in;
      rsp_id_ff   <= rsp_id_in;
      rsp_last_ff <= rsp_last_in;
   end

   always_comb begin
      state_in    = state_ff;
      n_in        = n_ff;
      idx_in      = idx_ff;
      j_in        = j_ff;
      chk_in      = chk_ff;
      hit_in      = hit_ff;
      pos_in      = pos_ff;
      moved_in    = moved_ff;
      px_in       = px_ff;
      py_in       = py_ff;
      rsp_load    = 1'b0;
      rsp_kind_in = rsp_kind_ff;
      rsp_hit_in  = rsp_hit_ff;
      rsp_pos_in  = rsp_pos_ff;
      rsp_id_in   = rsp_id_ff;
      rsp_last_in = rsp_last_ff;
      ram_wr_en   = 1'b0;
      ram_wr_addr = '0;
      ram_wr_data = moved_ff;
      ram_rd_en   = 1'b0;
      ram_rd_addr = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               unique case (req_tuser)
                  OP_LOAD: begin
                     // loads past the store are dropped
                     if (32'(req_slot) < MAX_WINDOWS) begin
                        ram_wr_en   = 1'b1;
                        ram_wr_addr = AW'(req_slot);
                        ram_wr_data = req_win;
                     end
                  end
                  OP_CLICK: begin
                     px_in  = req_px;
                     py_in  = req_py;
                     n_in   = n_sat;
                     idx_in = '0;
                     chk_in = 1'b0;
                     hit_in = 1'b0;
                     state_in = (n_sat == '0) ? ST_CLK_OUT : ST_SCAN;
                  end
                  OP_DUMP: begin
                     n_in   = n_sat;
                     idx_in = '0;
                     if (n_sat != '0) begin
                        state_in = ST_DUMP_RD;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end

         ST_SCAN: begin
            // one read issued per cycle; the compare checks the slot read the cycle before
            if (chk_ff && win_hit) begin
               hit_in   = 1'b1;
               pos_in   = POS_W'(idx_ff - 1'b1);
               j_in     = idx_ff - 1'b1;
               moved_in = ram_rd_data;
               state_in = ST_SH_RD;
            end else if (chk_ff && (idx_ff == n_ff)) begin
               hit_in   = 1'b0;
               state_in = ST_CLK_OUT;
            end else begin
               ram_rd_en   = 1'b1;
               ram_rd_addr = AW'(idx_ff);
               idx_in      = idx_ff + 1'b1;
               chk_in      = 1'b1;
            end
         end

         ST_SH_RD: begin
            if (j_ff == '0) begin
               // top slot takes the hit window
               ram_wr_en   = 1'b1;
               ram_wr_addr = '0;
               ram_wr_data = moved_ff;
               state_in    = ST_CLK_OUT;
            end else begin
               ram_rd_en   = 1'b1;
               ram_rd_addr = AW'(j_ff - 1'b1);
               state_in    = ST_SH_WR;
            end
         end

         ST_SH_WR: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = AW'(j_ff);
            ram_wr_data = ram_rd_data;
            j_in        = j_ff - 1'b1;
            state_in    = ST_SH_RD;
         end

         ST_CLK_OUT: begin
            if (out_free) begin
               rsp_load    = 1'b1;
               rsp_kind_in = KIND_CLICK;
               rsp_hit_in  = hit_ff;
               rsp_pos_in  = hit_ff ? pos_ff : '0;
               rsp_id_in   = hit_ff ? moved_ff.id : '0;
               rsp_last_in = 1'b1;
               state_in    = ST_IDLE;
            end
         end

         ST_DUMP_RD: begin
            ram_rd_en   = 1'b1;
            ram_rd_addr = AW'(idx_ff);
            state_in    = ST_DUMP_OUT;
         end

         ST_DUMP_OUT: begin
            // RAM output holds until the result register frees up
            if (out_free) begin
               rsp_load    = 1'b1;
               rsp_kind_in = KIND_DUMP;
               rsp_hit_in  = 1'b0;
               rsp_pos_in  = POS_W'(idx_ff);
               rsp_id_in   = ram_rd_data.id;
               rsp_last_in = ((idx_ff + 1'b1) == n_ff);
               if ((idx_ff + 1'b1) == n_ff) begin
                  state_in = ST_IDLE;
               end else begin
                  idx_in   = idx_ff + 1'b1;
                  state_in = ST_DUMP_RD;
               end
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {3'b000, rsp_id_ff, rsp_pos_ff, rsp_hit_ff};
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

`default_nettype wire

FILE: rtl/core/wsh_checker.sv
// Port-level checks on the response channel of the window stack,
// bound into window_stack_hit_to_front. Depends on wsh_pkg.
`default_nettype none

module wsh_checker
   import wsh_pkg::*;
(
   input wire logic                  clock,
   input wire logic                  reset,
   input wire logic                  rsp_tvalid,
   input wire logic                  rsp_tready,
   input wire logic [RSP_DATA_W-1:0] rsp_tdata,
   input wire logic                  rsp_tuser,
   input wire logic                  rsp_tlast
);

   // no response straight out of reset
   a_reset_idle: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("response valid after reset");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=>
         rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("stalled response changed");

   // a click answer is always a single, final transaction
   a_click_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == KIND_CLICK) |-> rsp_tlast)
      else $error("click answer without last");

   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == KIND_CLICK) && !rsp_tdata[0] |-> (rsp_tdata[20:1] == '0))
      else $error("miss carries nonzero position or id");

   a_dump_nohit: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == KIND_DUMP) |-> !rsp_tdata[0])
      else $error("dump entry flagged as hit");

endmodule

bind window_stack_hit_to_front wsh_checker u_wsh_checker (.*);

`default_nettype wire

FILE: verif/window_stack_hit_to_front_tb.sv
// Self-checking testbench for window_stack_hit_to_front: loads, clicks and dumps
// on the request stream, with results checked against a move-to-front predictor.
// Depends on wsh_pkg and the window_stack_hit_to_front RTL.
module window_stack_hit_to_front_tb
   import wsh_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [1:0] OP_UNUSED = 2'd3;
   // settle time scales with the stack depth
   localparam int SETTLE_CYCLES  = 3 * MAX_WINDOWS_DEF + 16;
   localparam int HOLDOFF_CYCLES = 300;

   typedef struct {
      logic [1:0]                opcode;
      logic [POS_W-1:0]          slot;
      window_type                win;
      logic signed [COORD_W-1:0] point_x;
      logic signed [COORD_W-1:0] point_y;
   } request_type;

   typedef struct {
      logic             kind;
      logic             hit;
      logic [POS_W-1:0] position;
      logic [ID_W-1:0]  result_id;
      logic             last;
   } answer_type;

   // Tracks the window stack and the answers it should produce.
   class stack_order_tracker;
      window_type       windows [POS_LIMIT];
      logic [CNT_W-1:0] window_count;
      answer_type       expected_answers [$];
      int               errors;

      function int unsigned active_windows();
         int unsigned n;
         n = window_count;
         if (n > MAX_WINDOWS_DEF) n = MAX_WINDOWS_DEF;
         if (n > POS_LIMIT) n = POS_LIMIT;
         return n;
      endfunction

      function bit holds_point(window_type w, logic signed [COORD_W-1:0] px,
                               logic signed [COORD_W-1:0] py);
         return ($signed(w.left) <= px) && (px <= $signed(w.right)) &&
                ($signed(w.bottom) <= py) && (py <= $signed(w.top));
      endfunction

      function void note_request(request_type req);
         int unsigned n;
         window_type  moved;
         answer_type  ans;
         n = active_windows();
         case (req.opcode)
            OP_LOAD: begin
               if (req.slot < MAX_WINDOWS_DEF) windows[req.slot] = req.win;
            end
            OP_CLICK: begin
               ans.kind      = KIND_CLICK;
               ans.hit       = 1'b0;
               ans.position  = '0;
               ans.result_id = '0;
               ans.last      = 1'b1;
               for (int i = 0; i < n; i++) begin
                  if (holds_point(windows[i], req.point_x, req.point_y)) begin
                     moved = windows[i];
                     for (int j = i; j >= 1; j--) windows[j] = windows[j-1];
                     windows[0]    = moved;
                     ans.hit       = 1'b1;
                     ans.position  = POS_W'(i);
                     ans.result_id = moved.id;
                     break;
                  end
               end
               expected_answers.push_back(ans);
            end
            OP_DUMP: begin
               for (int i = 0; i < n; i++) begin
                  ans.kind      = KIND_DUMP;
                  ans.hit       = 1'b0;
                  ans.position  = POS_W'(i);
                  ans.result_id = windows[i].id;
                  ans.last      = (i + 1 == n);
                  expected_answers.push_back(ans);
               end
            end
            default: ;
         endcase
      endfunction

      task report(string msg);
         $display("%0t ns mismatch: %s", $time, msg);
         errors++;
      endtask

      task check_answer(logic kind, logic hit, logic [POS_W-1:0] position,
                        logic [ID_W-1:0] result_id, logic last);
         answer_type exp;
         if (expected_answers.size() == 0) begin
            report($sformatf("unexpected response kind %0d id %h", kind, result_id));
            return;
         end
         exp = expected_answers.pop_front();
         if (kind !== exp.kind)
            report($sformatf("kind got %0d exp %0d", kind, exp.kind));
         if (hit !== exp.hit)
            report($sformatf("hit got %0d exp %0d", hit, exp.hit));
         if (position !== exp.position)
            report($sformatf("position got %0d exp %0d", position, exp.position));
         if (result_id !== exp.result_id)
            report($sformatf("id got %h exp %h", result_id, exp.result_id));
         if (last !== exp.last)
            report($sformatf("last got %0d exp %0d", last, exp.last));
      endtask
   endclass

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;
   logic [1:0]            req_tuser;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tuser;
   logic                  rsp_tlast;
   logic                  csr_wr_en;
   logic [CNT_W-1:0]      csr_wr_data;

   stack_order_tracker tracker;
   logic               holding;
   event               hold_go;
   int                 burst_left = 0;
   int                 rx_cycle = 0;

   window_stack_hit_to_front #(
      .MAX_WINDOWS (MAX_WINDOWS_DEF)
   ) u_top (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      // slot, window_id, left_x, top_y, right_x, bottom_y, point_x, point_y, pad
      .req_tdata   (req_tdata),
      // opcode
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      // hit, position, result_id, pad
      .rsp_tdata   (rsp_tdata),
      // kind
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Response side: check every transaction, then pick next cycle's ready.
   // The stall pattern rotates through four modes as rx_cycle advances; a pending
   // hold-off forces ready low no matter what the pattern says.
   always @(posedge clock) begin : rsp_side
      bit ready_next;
      if (!reset && rsp_tvalid && rsp_tready)
         tracker.check_answer(rsp_tuser, rsp_tdata[0], rsp_tdata[4:1],
                              rsp_tdata[20:5], rsp_tlast);
      case ((rx_cycle / 97) % 4)
         0:       ready_next = 1'b1;
         1:       ready_next = ($urandom_range(0, 99) < 60);
         2:       ready_next = ((rx_cycle % 5) != 0);
         default: ready_next = ((rx_cycle % 16) < 4);
      endcase
      rsp_tready <= ready_next && !holding;
      rx_cycle   <= rx_cycle + 1;
   end

   // Long receiver hold-off, counted here so the sender keeps offering
   // transactions and the block backs up into its request side.
   initial begin
      holding = 1'b0;
      forever begin
         @(hold_go);
         @(posedge clock);
         holding <= 1'b1;
         repeat (HOLDOFF_CYCLES) @(posedge clock);
         holding <= 1'b0;
      end
   end

   // Hard stop in case the block hangs.
   initial begin
      #2_000_000;
      $display("window_stack_hit_to_front_tb: done, errors");
      $finish;
   end

   // Every field random; generators then overwrite what matters.
   function automatic request_type random_request();
      request_type req;
      req.opcode     = 2'($urandom);
      req.slot       = POS_W'($urandom);
      req.win.id     = 16'($urandom);
      req.win.left   = 16'($urandom);
      req.win.top    = 16'($urandom);
      req.win.right  = 16'($urandom);
      req.win.bottom = 16'($urandom);
      req.point_x    = 16'($urandom);
      req.point_y    = 16'($urandom);
      return req;
   endfunction

   function automatic request_type make_load(int slot);
      request_type req;
      int          l;
      int          r;
      int          b;
      int          t;
      req        = random_request();
      req.opcode = OP_LOAD;
      req.slot   = POS_W'(slot);
      // mostly proper rectangles; some raw ones, possibly inverted
      if ($urandom_range(0, 7) != 0) begin
         l = $urandom_range(0, 65535) - 32768;
         b = $urandom_range(0, 65535) - 32768;
         r = l + $urandom_range(0, 6000);
         t = b + $urandom_range(0, 6000);
         if (r > 32767) r = 32767;
         if (t > 32767) t = 32767;
         req.win.left   = 16'(l);
         req.win.right  = 16'(r);
         req.win.bottom = 16'(b);
         req.win.top    = 16'(t);
      end
      return req;
   endfunction

   // Clicks aim mostly at a live window: inside, on an edge, or one step out.
   function automatic request_type make_click();
      request_type req;
      int          n;
      int          k;
      int          sel;
      int          l;
      int          r;
      int          b;
      int          t;
      int          px;
      int          py;
      req        = random_request();
      req.opcode = OP_CLICK;
      n          = tracker.active_windows();
      sel        = $urandom_range(0, 9);
      if (n > 0 && sel < 7) begin
         k = $urandom_range(0, n - 1);
         l = $signed(tracker.windows[k].left);
         r = $signed(tracker.windows[k].right);
         b = $signed(tracker.windows[k].bottom);
         t = $signed(tracker.windows[k].top);
         if (l <= r && b <= t) begin
            px = (sel == 0) ? l : (sel == 1) ? r : l + $urandom_range(0, r - l);
            py = (sel == 0) ? t : (sel == 1) ? b : b + $urandom_range(0, t - b);
            if (sel == 2 && l > -32768) px = l - 1;
            if (sel == 3 && t < 32767) py = t + 1;
            req.point_x = 16'(px);
            req.point_y = 16'(py);
         end
      end
      return req;
   endfunction

   function automatic request_type make_random_item();
      request_type req;
      int          pick;
      pick = $urandom_range(0, 99);
      if (pick < 22) return make_load($urandom_range(0, 15));
      if (pick < 75) return make_click();
      req        = random_request();
      req.opcode = (pick < 95) ? OP_DUMP : OP_UNUSED;
      return req;
   endfunction

   // Offer one transaction and hold it until accepted. Valid stays high into
   // the next transaction unless the burst is over, in which case a gap follows.
   task automatic send_item(request_type req, bit allow_gap);
      int gap;
      req_tvalid <= 1'b1;
      req_tuser  <= req.opcode;
      req_tdata  <= {4'b0, req.point_y, req.point_x, req.win.bottom, req.win.right,
                     req.win.top, req.win.left, req.win.id, req.slot};
      do @(posedge clock); while (!req_tready);
      tracker.note_request(req);
      if (allow_gap) begin
         if (burst_left > 0) begin
            burst_left--;
         end else begin
            gap        = $urandom_range(1, 12);
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 40)
                                                     : $urandom_range(0, 8);
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   task automatic send_op(logic [1:0] opcode, bit allow_gap);
      request_type req;
      req        = random_request();
      req.opcode = opcode;
      send_item(req, allow_gap);
   endtask

   task automatic click_at(int x, int y);
      request_type req;
      req         = random_request();
      req.opcode  = OP_CLICK;
      req.point_x = 16'(x);
      req.point_y = 16'(y);
      send_item(req, 1'b1);
   endtask

   task automatic load_rect(int slot, logic [ID_W-1:0] id, int l, int t, int r, int b);
      request_type req;
      req            = random_request();
      req.opcode     = OP_LOAD;
      req.slot       = POS_W'(slot);
      req.win.id     = id;
      req.win.left   = 16'(l);
      req.win.top    = 16'(t);
      req.win.right  = 16'(r);
      req.win.bottom = 16'(b);
      send_item(req, 1'b1);
   endtask

   task automatic run_random(int count);
      for (int i = 0; i < count; i++) send_item(make_random_item(), 1'b1);
   endtask

   // Drop valid, drain all expected responses, then let a load or an ignored
   // transaction still in flight finish before touching the register.
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (tracker.expected_answers.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_count(logic [CNT_W-1:0] value);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      tracker.window_count = value;
   endtask

   initial begin
      tracker     = new();
      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      req_tuser   = OP_LOAD;
      csr_wr_en   = 1'b0;
      csr_wr_data = '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      write_count(5'd0);

      // Empty stack: a click misses, a dump says nothing, opcode 3 is dropped.
      click_at(0, 0);
      send_op(OP_DUMP, 1'b1);
      send_op(OP_UNUSED, 1'b1);

      // Fill every slot before any count exposes it. Slots 0..14 form a
      // non-overlapping grid; slot 15 covers the whole plane.
      for (int k = 0; k < 15; k++)
         load_rect(k, (k == 0) ? 16'h0000 : 16'h1000 + k[15:0],
                   -30000 + k * 3600, -18000 + k * 2500,
                   -27000 + k * 3600, -20000 + k * 2500);
      load_rect(15, 16'hFFFF, -32768, 32767, 32767, -32768);
      wait_idle();
      write_count(5'd16);

      // Edge-inclusive hits, a near miss that falls through to the bottom
      // window (longest shift), the plane corners, then the full order.
      click_at($signed(tracker.windows[3].left), $signed(tracker.windows[3].top));
      click_at($signed(tracker.windows[5].right), $signed(tracker.windows[5].bottom));
      click_at($signed(tracker.windows[2].left) - 1,
               $signed(tracker.windows[2].bottom));
      click_at(-32768, -32768);
      click_at(32767, 32767);
      send_op(OP_DUMP, 1'b1);

      run_random(15);
      // Receiver holds off while full dumps keep coming back to back.
      -> hold_go;
      repeat (4) send_op(OP_DUMP, 1'b0);
      run_random(15);
      wait_idle();

      // Count above the store saturates to the full stack.
      write_count(5'd31);
      run_random(25);
      wait_idle();

      write_count(5'd1);
      run_random(15);
      wait_idle();

      write_count(5'd0);
      run_random(10);
      wait_idle();

      write_count(5'd9);
      run_random(20);
      wait_idle();

      write_count(CNT_W'($urandom_range(2, 15)));
      run_random(20);
      wait_idle();

      if (tracker.errors == 0) begin
         $display("window_stack_hit_to_front_tb: done, clean");
      end else begin
         $display("window_stack_hit_to_front_tb: done, errors");
      end
      $finish;
   end

endmodule
